/* sv/vse_pkg.sv */
package vse_pkg;

   // Default grid size: interior side and number of height levels
   localparam int SIDE_DEFAULT   = 16;
   localparam int LEVELS_DEFAULT = 64;

   // Field widths
   localparam int POS_W  = 6;
   localparam int BASE_W = 11;
   localparam int Z_W    = 12;
   localparam int ZIDX_W = 8;

   // Scan position decode handed from the counters to the stencil stage
   typedef struct packed {
      logic              report;
      logic              last;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [ZIDX_W-1:0] z_index;
   } scan_info_type;

endpackage

/* sv/vse_channels.sv */
// Voxel input channel
interface vse_req_if;
   logic valid;
   logic ready;
   logic air_bit;
   logic frame_start;

   modport source (output valid, output air_bit, output frame_start, input ready);
   modport sink   (input valid, input air_bit, input frame_start, output ready);
endinterface

// Surface result channel
interface vse_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            is_surface;
   logic [vse_pkg::POS_W-1:0]       pos_x;
   logic [vse_pkg::POS_W-1:0]       pos_y;
   logic signed [vse_pkg::Z_W-1:0]  pos_z;
   logic                            frame_end;

   modport source (output valid, output is_surface, output pos_x, output pos_y,
                   output pos_z, output frame_end, input ready);
   modport sink   (input valid, input is_surface, input pos_x, input pos_y,
                   input pos_z, input frame_end, output ready);
endinterface

// Height base register write channel
interface vse_csr_if;
   logic                              valid;
   logic                              ready;
   logic signed [vse_pkg::BASE_W-1:0] height_base;

   modport source (output valid, output height_base, input ready);
   modport sink   (input valid, input height_base, output ready);
endinterface

/* sv/vse_cell.sv */
// One row segment of the voxel delay line. Shifts one bit in per accepted
// beat; bit 0 is the newest. All bits are visible as stencil taps.
module vse_cell #(
   parameter int LEN = 66
) (
   input  logic           clock,
   input  logic           shift_en,
   input  logic           bit_in,
   output logic [LEN-1:0] taps,
   output logic           bit_out
);

   logic [LEN-1:0] data_ff;
   logic [LEN-1:0] data_in;

   // shift toward the older end
   always_comb begin
      data_in = {data_ff[LEN-2:0], bit_in};
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign taps    = data_ff;
   assign bit_out = data_ff[LEN-1];

endmodule

/* sv/vse_scan.sv */
// Padded-grid position counters (plane, row, level) and the decode of the
// interior voxel whose stencil the current beat completes.
module vse_scan #(
   parameter int SIDE   = vse_pkg::SIDE_DEFAULT,
   parameter int LEVELS = vse_pkg::LEVELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   frame_start,
   output vse_pkg::scan_info_type info
);

   localparam int ROWLEN = LEVELS + 2;
   localparam int A_W    = $clog2(SIDE + 2);
   localparam int C_W    = $clog2(ROWLEN);

   logic [A_W-1:0] a_ff, a_in, a_cur;
   logic [A_W-1:0] b_ff, b_in, b_cur;
   logic [C_W-1:0] c_ff, c_in, c_cur;
   logic [A_W-1:0] a_off;
   logic [A_W-1:0] b_off;
   logic [C_W-1:0] c_off;

   // frame start forces the position of this beat to the origin
   always_comb begin
      a_cur = frame_start ? '0 : a_ff;
      b_cur = frame_start ? '0 : b_ff;
      c_cur = frame_start ? '0 : c_ff;
   end

   // raster advance: level innermost, then row, then plane
   always_comb begin
      a_in = a_cur;
      b_in = b_cur;
      c_in = c_cur + C_W'(1);
      if (c_cur == C_W'(ROWLEN - 1)) begin
         c_in = '0;
         b_in = b_cur + A_W'(1);
         if (b_cur == A_W'(SIDE + 1)) begin
            b_in = '0;
            a_in = a_cur + A_W'(1);
            if (a_cur == A_W'(SIDE + 1)) begin
               a_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
      end else if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   // interior voxel one plane back at the same row and level
   always_comb begin
      a_off = a_cur - A_W'(2);
      b_off = b_cur - A_W'(1);
      c_off = c_cur - C_W'(1);
      info.report  = (a_cur >= A_W'(2)) &&
                     (b_cur >= A_W'(1)) && (b_cur <= A_W'(SIDE)) &&
                     (c_cur >= C_W'(1)) && (c_cur <= C_W'(LEVELS));
      info.last    = (a_cur == A_W'(SIDE + 1)) && (b_cur == A_W'(SIDE)) &&
                     (c_cur == C_W'(LEVELS));
      info.pos_x   = vse_pkg::POS_W'(a_off);
      info.pos_y   = vse_pkg::POS_W'(b_off);
      info.z_index = vse_pkg::ZIDX_W'(c_off);
   end

endmodule

/* sv/voxel_surface_extract_top.sv */
// Streaming six-neighbor surface extraction. Voxels of a padded grid of
// (SIDE+2) x (SIDE+2) x (LEVELS+2) bits arrive one per beat, first axis
// outermost and height innermost; frame_start restarts the position at the
// origin. A beat is taken every cycle unless the single result register
// holds an unread result, and each beat that completes the stencil of an
// interior voxel yields its result in the next cycle. The stencil sees the
// last two planes through a delay line of 2*(SIDE+2) row cells, each of
// LEVELS+2 bits, that shifts once per beat; it needs no clearing after reset
// since results start only once two planes of a grid are in. height_base is to
// be written through the csr channel while the block is idle (not enforced).
module voxel_surface_extract_top #(
   parameter int SIDE   = vse_pkg::SIDE_DEFAULT,
   parameter int LEVELS = vse_pkg::LEVELS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   vse_req_if.sink   req_bus,
   vse_rsp_if.source rsp_bus,
   vse_csr_if.sink   csr_bus
);

   localparam int ROWLEN   = LEVELS + 2;
   localparam int PLANE    = (SIDE + 2) * ROWLEN;
   localparam int NCELLS   = 2 * (SIDE + 2);
   localparam int LINE_LEN = NCELLS * ROWLEN;

   // tap k holds the bit from k beats ago
   localparam int T_OLDER  = 2 * PLANE;
   localparam int T_CENTER = PLANE;
   localparam int T_ROW_UP = PLANE - ROWLEN;
   localparam int T_ROW_DN = PLANE + ROWLEN;
   localparam int T_LVL_UP = PLANE - 1;
   localparam int T_LVL_DN = PLANE + 1;

   logic                              accept;
   logic                              req_ready;
   vse_pkg::scan_info_type            info;
   logic [LINE_LEN-1:0]               line_bits;
   logic [NCELLS:0]                   chain;
   logic                              any_air;
   logic                              surface;
   logic signed [vse_pkg::Z_W-1:0]    pos_z;
   logic signed [vse_pkg::BASE_W-1:0] height_base_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              is_surface_ff;
   logic [vse_pkg::POS_W-1:0]         pos_x_ff;
   logic [vse_pkg::POS_W-1:0]         pos_y_ff;
   logic signed [vse_pkg::Z_W-1:0]    pos_z_ff;
   logic                              frame_end_ff;

   // input beat taken whenever the result register is free or draining
   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;

   // position counters
   vse_scan #(
      .SIDE   (SIDE),
      .LEVELS (LEVELS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_bus.frame_start),
      .info        (info)
   );

   // delay line of row cells
   assign chain[0] = req_bus.air_bit;

   for (genvar g = 0; g < NCELLS; g++) begin : g_cell
      vse_cell #(
         .LEN (ROWLEN)
      ) u_cell (
         .clock    (clock),
         .shift_en (accept),
         .bit_in   (chain[g]),
         .taps     (line_bits[g*ROWLEN +: ROWLEN]),
         .bit_out  (chain[g+1])
      );
   end

   // six-neighbor stencil on the voxel one plane back
   always_comb begin
      any_air = req_bus.air_bit |
                line_bits[T_OLDER-1]  |
                line_bits[T_ROW_UP-1] | line_bits[T_ROW_DN-1] |
                line_bits[T_LVL_UP-1] | line_bits[T_LVL_DN-1];
      surface = !line_bits[T_CENTER-1] && any_air;
      pos_z   = {height_base_ff[vse_pkg::BASE_W-1], height_base_ff} +
                vse_pkg::Z_W'(info.z_index);
   end

   // height base register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_base_ff <= '0;
      end else if (csr_bus.valid) begin
         height_base_ff <= csr_bus.height_base;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (accept && info.report) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && info.report) begin
         is_surface_ff <= surface;
         pos_x_ff      <= info.pos_x;
         pos_y_ff      <= info.pos_y;
         pos_z_ff      <= pos_z;
         frame_end_ff  <= info.last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.is_surface = is_surface_ff;
   assign rsp_bus.pos_x      = pos_x_ff;
   assign rsp_bus.pos_y      = pos_y_ff;
   assign rsp_bus.pos_z      = pos_z_ff;
   assign rsp_bus.frame_end  = frame_end_ff;

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE        = vse_pkg::SIDE_DEFAULT;
   localparam int LEVELS      = vse_pkg::LEVELS_DEFAULT;
   localparam int ROWLEN      = LEVELS + 2;
   localparam int PLANE       = (SIDE + 2) * ROWLEN;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic                             is_surface;
      logic [vse_pkg::POS_W-1:0]        pos_x;
      logic [vse_pkg::POS_W-1:0]        pos_y;
      logic signed [vse_pkg::Z_W-1:0]   pos_z;
      logic                             frame_end;
   } surface_beat_type;

   // Tracks the padded scan position and the last two planes, predicts
   // the surface beat for each voxel and checks the returned beats in order
   class voxel_surface_board #(int SIDE = 16, int LEVELS = 64);
      bit                                plane_bits [2][SIDE+2][LEVELS+2];
      int unsigned                       plane, row, level;
      logic signed [vse_pkg::BASE_W-1:0] height_base;
      surface_beat_type                  surface_due [$];
      int                                errors;

      function new();
         plane = 0;
         row = 0;
         level = 0;
         height_base = '0;
         errors = 0;
      endfunction

      function void report(string what, longint want, longint got);
         errors++;
         if (errors <= 40)
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      endfunction

      // One accepted voxel beat
      function void take_voxel(bit air, bit frame_start);
         bit               cur_slot;
         bit               older;
         bit               center;
         bit               any_air;
         int               z;
         surface_beat_type want;
         if (frame_start) begin
            plane = 0;
            row = 0;
            level = 0;
         end
         cur_slot = plane[0];
         older = plane_bits[cur_slot][row][level];

         // the stencil of the voxel one plane back is complete now
         if (plane >= 2 && row >= 1 && row <= SIDE && level >= 1 && level <= LEVELS) begin
            center = plane_bits[!cur_slot][row][level];
            any_air = older | air |
                      plane_bits[!cur_slot][row+1][level] |
                      plane_bits[!cur_slot][row-1][level] |
                      plane_bits[!cur_slot][row][level+1] |
                      plane_bits[!cur_slot][row][level-1];
            z = int'(height_base) + int'(level) - 1;
            want.is_surface = !center && any_air;
            want.pos_x = vse_pkg::POS_W'(plane - 2);
            want.pos_y = vse_pkg::POS_W'(row - 1);
            want.pos_z = z[vse_pkg::Z_W-1:0];
            want.frame_end = (plane == SIDE + 1 && row == SIDE && level == LEVELS);
            surface_due.push_back(want);
         end
         plane_bits[cur_slot][row][level] = air;

         // advance: height innermost, wrap to the origin after a full grid
         level++;
         if (level == LEVELS + 2) begin
            level = 0;
            row++;
            if (row == SIDE + 2) begin
               row = 0;
               plane++;
               if (plane == SIDE + 2)
                  plane = 0;
            end
         end
      endfunction

      // One accepted result beat
      function void check_surface(surface_beat_type got);
         surface_beat_type want;
         if (surface_due.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: expected no result, actual x=%0d y=%0d z=%0d", $time,
                        got.pos_x, got.pos_y, got.pos_z);
            return;
         end
         want = surface_due.pop_front();
         if (got.is_surface !== want.is_surface)
            report("is_surface", want.is_surface, got.is_surface);
         if (got.pos_x !== want.pos_x)
            report("pos_x", want.pos_x, got.pos_x);
         if (got.pos_y !== want.pos_y)
            report("pos_y", want.pos_y, got.pos_y);
         if (got.pos_z !== want.pos_z)
            report("pos_z", longint'(want.pos_z), longint'(got.pos_z));
         if (got.frame_end !== want.frame_end)
            report("frame_end", want.frame_end, got.frame_end);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   vse_req_if req_bus ();
   vse_rsp_if rsp_bus ();
   vse_csr_if csr_bus ();

   voxel_surface_board #(SIDE, LEVELS) board;

   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          rsp_stall = 0;
   int unsigned quiet_cycles = 0;

   voxel_surface_extract_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
         rsp_stall <= $urandom_range(2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_surface({rsp_bus.is_surface, rsp_bus.pos_x, rsp_bus.pos_y,
                              rsp_bus.pos_z, rsp_bus.frame_end});
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one voxel beat, with an optional gap in front
   task automatic send_voxel(bit air, bit frame_start);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.air_bit <= air;
      req_bus.frame_start <= frame_start;
      do @(posedge clock); while (!req_bus.ready);
      board.take_voxel(air, frame_start);
   endtask

   // a run of voxels; shell forces the padded border to air,
   // stray_fs is the chance of a stray frame start in 1/10000
   task automatic send_grid(int count, int air_pct, bit start, bit shell, int stray_fs);
      int p;
      int r;
      int l;
      bit air;
      bit fs;
      for (int i = 0; i < count; i++) begin
         p = i / PLANE;
         r = (i % PLANE) / ROWLEN;
         l = i % ROWLEN;
         air = ($urandom_range(99) < air_pct);
         if (shell && (p == 0 || p == SIDE + 1 || r == 0 || r == SIDE + 1 ||
                       l == 0 || l == LEVELS + 1))
            air = 1'b1;
         fs = (start && i == 0) || ($urandom_range(9999) < stray_fs);
         send_voxel(air, fs);
      end
   endtask

   // stop sending, wait for all results and let the pipe empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.surface_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_height_base(int value);
      csr_bus.valid <= 1'b1;
      csr_bus.height_base <= value[vse_pkg::BASE_W-1:0];
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      board.height_base = value[vse_pkg::BASE_W-1:0];
   endtask

   initial begin
      board = new();
      req_bus.valid <= 1'b0;
      req_bus.air_bit <= 1'b0;
      req_bus.frame_start <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.height_base <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short directed run: repeated restarts before any stencil completes
      for (int i = 0; i < 20; i++)
         send_voxel(i[0], (i % 6) == 0);
      settle();

      // lowest base, half air: two planes to fill, then the first rows of the third
      write_height_base(-1024);
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      send_grid(2 * PLANE + 4 * ROWLEN, 50, 1'b1, 1'b0, 0);
      settle();

      // highest base, same grid carried on, result side often stalled
      write_height_base(1023);
      req_idle_pct = 10;
      rsp_idle_pct = 40;
      send_grid(2 * ROWLEN, 20, 1'b0, 1'b0, 0);
      settle();

      // random base, mostly solid
      write_height_base($urandom_range(2047) - 1024);
      req_idle_pct = 30;
      rsp_idle_pct = 0;
      send_grid(ROWLEN, 3, 1'b0, 1'b0, 0);
      settle();

      // last rows at full rate, mostly air
      write_height_base(-1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_grid(2 * ROWLEN, 95, 1'b0, 1'b0, 0);
      settle();

      if (board.errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* sim.f */
sv/vse_pkg.sv
sv/vse_channels.sv
sv/vse_cell.sv
sv/vse_scan.sv
sv/voxel_surface_extract_top.sv
tb/testbench.sv
